@@ hdl/dmc_pkg.sv @@
// Shared constants, codes and types of the direct-mapped write-back cache.
package dmc_pkg;

    localparam int DEF_NUM_LINES      = 512;
    localparam int DEF_WORDS_PER_LINE = 16;
    localparam int DEF_WORD_BYTES     = 4;

    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 32;
    localparam int TDATA_W  = 64;
    localparam int S_USER_W = 2;
    localparam int M_USER_W = 3;

    // request codes on the slave side
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_WB    = 2'd2,
        KIND_FILL  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WB_RD,
        ST_WB_OUT,
        ST_FILL_REQ,
        ST_FILL_DONE,
        ST_COMPLETE
    } state_t;

endpackage

@@ hdl/dmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/dmc_ctrl.sv @@
// Sequencer and datapath: tag compare, writeback, fill and output register.
module dmc_ctrl #(
    parameter int NUM_LINES      = dmc_pkg::DEF_NUM_LINES,
    parameter int WORDS_PER_LINE = dmc_pkg::DEF_WORDS_PER_LINE,
    parameter int WORD_BYTES     = dmc_pkg::DEF_WORD_BYTES,
    parameter int IDX_W          = $clog2(NUM_LINES),
    parameter int WSEL_W         = $clog2(WORDS_PER_LINE),
    parameter int OFF_W          = $clog2(WORDS_PER_LINE * WORD_BYTES),
    parameter int TAG_W          = dmc_pkg::ADDR_W - OFF_W - IDX_W
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  req_type,
    input  logic [dmc_pkg::ADDR_W-1:0]  address,
    input  logic [dmc_pkg::DATA_W-1:0]  data_in,
    // master side
    output logic                        m_valid,
    input  logic                        m_ready,
    output dmc_pkg::kind_t              result_kind,
    output logic [dmc_pkg::ADDR_W-1:0]  mem_address,
    output logic [dmc_pkg::DATA_W-1:0]  data_out,
    output logic                        was_hit,
    output logic                        last,
    // tag RAM: {valid, dirty, tag}
    output logic                        meta_we,
    output logic [IDX_W-1:0]            meta_waddr,
    output logic [TAG_W+1:0]            meta_wdata,
    output logic                        meta_re,
    output logic [IDX_W-1:0]            meta_raddr,
    input  logic [TAG_W+1:0]            meta_rdata,
    // line word RAM
    output logic                        data_we,
    output logic [IDX_W+WSEL_W-1:0]     data_waddr,
    output logic [dmc_pkg::DATA_W-1:0]  data_wdata,
    output logic                        data_re,
    output logic [IDX_W+WSEL_W-1:0]     data_raddr,
    input  logic [dmc_pkg::DATA_W-1:0]  data_rdata
);

    import dmc_pkg::*;

    localparam int BYTE_W = $clog2(WORD_BYTES);

    state_t               state_reg, state_next;
    logic                 await_reg, await_next;
    logic [WSEL_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic                 hit_reg, hit_next;
    logic                 is_wr_reg, is_wr_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [DATA_W-1:0]    wdat_reg, wdat_next;
    logic [TAG_W-1:0]     vtag_reg, vtag_next;

    logic                 out_valid_reg, out_valid_next;
    kind_t                out_kind_reg, out_kind_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic                 out_hit_reg, out_hit_next;
    logic                 out_last_reg, out_last_next;

    logic                 can_load;
    logic                 load;
    logic [IDX_W-1:0]     s_idx;
    logic [WSEL_W-1:0]    s_word;
    logic [IDX_W-1:0]     p_idx;
    logic [WSEL_W-1:0]    p_word;
    logic [TAG_W-1:0]     p_tag;
    logic                 m_vld;
    logic                 m_dty;
    logic [TAG_W-1:0]     m_tag;

    assign s_idx  = address[OFF_W +: IDX_W];
    assign s_word = address[OFF_W-1 -: WSEL_W];
    assign p_idx  = addr_reg[OFF_W +: IDX_W];
    assign p_word = addr_reg[OFF_W-1 -: WSEL_W];
    assign p_tag  = addr_reg[ADDR_W-1 -: TAG_W];
    assign m_vld  = meta_rdata[TAG_W+1];
    assign m_dty  = meta_rdata[TAG_W];
    assign m_tag  = meta_rdata[TAG_W-1:0];

    assign can_load = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        await_next    = await_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        hit_next      = hit_reg;
        is_wr_next    = is_wr_reg;
        addr_next     = addr_reg;
        wdat_next     = wdat_reg;
        vtag_next     = vtag_reg;
        load          = 1'b0;
        out_kind_next = out_kind_reg;
        out_addr_next = out_addr_reg;
        out_data_next = out_data_reg;
        out_hit_next  = out_hit_reg;
        out_last_next = out_last_reg;
        meta_we       = 1'b0;
        meta_waddr    = p_idx;
        meta_wdata    = '0;
        meta_re       = 1'b0;
        meta_raddr    = s_idx;
        data_we       = 1'b0;
        data_waddr    = {p_idx, p_word};
        data_wdata    = wdat_reg;
        data_re       = 1'b0;
        data_raddr    = {p_idx, p_word};

        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (await_reg)
                    begin
                        if (req_type == REQ_FILL)
                        begin
                            data_we    = 1'b1;
                            data_waddr = {p_idx, cnt_reg};
                            data_wdata = data_in;
                            cnt_next   = cnt_reg + 1'b1;
                            if (&cnt_reg)
                            begin
                                await_next = 1'b0;
                                state_next = ST_FILL_DONE;
                            end
                        end
                    end
                    else if (req_type == REQ_READ || req_type == REQ_WRITE)
                    begin
                        is_wr_next = (req_type == REQ_WRITE);
                        addr_next  = address;
                        wdat_next  = data_in;
                        meta_re    = 1'b1;
                        meta_raddr = s_idx;
                        data_re    = 1'b1;
                        data_raddr = {s_idx, s_word};
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                vtag_next = m_tag;
                if (m_vld && m_tag == p_tag)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_COMPLETE;
                end
                else
                begin
                    hit_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = (m_vld && m_dty) ? ST_WB_RD : ST_FILL_REQ;
                end
            end
            ST_WB_RD:
            begin
                data_re    = 1'b1;
                data_raddr = {p_idx, cnt_reg};
                state_next = ST_WB_OUT;
            end
            ST_WB_OUT:
            begin
                if (can_load)
                begin
                    load          = 1'b1;
                    out_kind_next = KIND_WB;
                    out_addr_next = ADDR_W'({vtag_reg, p_idx, cnt_reg}) << BYTE_W;
                    out_data_next = data_rdata;
                    out_hit_next  = 1'b0;
                    out_last_next = 1'b0;
                    cnt_next      = cnt_reg + 1'b1;
                    state_next    = (&cnt_reg) ? ST_FILL_REQ : ST_WB_RD;
                end
            end
            ST_FILL_REQ:
            begin
                if (can_load)
                begin
                    load          = 1'b1;
                    out_kind_next = KIND_FILL;
                    out_addr_next = ADDR_W'({p_tag, p_idx}) << OFF_W;
                    out_data_next = '0;
                    out_hit_next  = 1'b0;
                    out_last_next = 1'b1;
                    // line goes invalid until the fill completes
                    meta_we       = 1'b1;
                    meta_wdata    = '0;
                    await_next    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FILL_DONE:
            begin
                meta_we    = 1'b1;
                meta_wdata = {1'b1, 1'b0, p_tag};
                data_re    = 1'b1;
                hit_next   = 1'b0;
                state_next = ST_COMPLETE;
            end
            ST_COMPLETE:
            begin
                if (can_load)
                begin
                    load          = 1'b1;
                    out_addr_next = '0;
                    out_hit_next  = hit_reg;
                    out_last_next = 1'b1;
                    if (is_wr_reg)
                    begin
                        data_we       = 1'b1;
                        meta_we       = 1'b1;
                        meta_wdata    = {1'b1, 1'b1, p_tag};
                        out_kind_next = KIND_WRITE;
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_kind_next = KIND_READ;
                        out_data_next = data_rdata;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            await_reg     <= 1'b0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            await_reg     <= await_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        is_wr_reg    <= is_wr_next;
        addr_reg     <= addr_next;
        wdat_reg     <= wdat_next;
        vtag_reg     <= vtag_next;
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign mem_address = out_addr_reg;
    assign data_out    = out_data_reg;
    assign was_hit     = out_hit_reg;
    assign last        = out_last_reg;

endmodule

@@ hdl/direct_mapped_writeback_cache.sv @@
// Hit: COMPLETE loads the result after LOOKUP; next word taken in the cycle after it loads.
// Clean miss: FILL_REQ offers the fill request after LOOKUP; dirty miss first offers each
// victim word, read one at a time through the line RAM port (WB_RD, WB_OUT).
// Fill words are taken one per cycle; the access result follows via FILL_DONE and COMPLETE.
// Reset clears control state, then a tag RAM clearing pass over every line runs with
// s_tready low. Line words are not cleared.
module direct_mapped_writeback_cache #(
    parameter int NUM_LINES      = dmc_pkg::DEF_NUM_LINES,       // power of two
    parameter int WORDS_PER_LINE = dmc_pkg::DEF_WORDS_PER_LINE,  // power of two
    parameter int WORD_BYTES     = dmc_pkg::DEF_WORD_BYTES       // power of two
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dmc_pkg::TDATA_W-1:0]   s_tdata,   // address[31:0], data_in[63:32]
    input  logic [dmc_pkg::S_USER_W-1:0]  s_tuser,   // req_type[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dmc_pkg::TDATA_W-1:0]   m_tdata,   // mem_address[31:0], data_out[63:32]
    output logic [dmc_pkg::M_USER_W-1:0]  m_tuser,   // result_kind[1:0], was_hit[2]
    output logic                          m_tlast
);

    import dmc_pkg::*;

    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int WSEL_W = $clog2(WORDS_PER_LINE);
    localparam int OFF_W  = $clog2(WORDS_PER_LINE * WORD_BYTES);
    localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
    localparam int META_W = TAG_W + 2;

    logic                    meta_we;
    logic [IDX_W-1:0]        meta_waddr;
    logic [META_W-1:0]       meta_wdata;
    logic                    meta_re;
    logic [IDX_W-1:0]        meta_raddr;
    logic [META_W-1:0]       meta_rdata;
    logic                    data_we;
    logic [IDX_W+WSEL_W-1:0] data_waddr;
    logic [DATA_W-1:0]       data_wdata;
    logic                    data_re;
    logic [IDX_W+WSEL_W-1:0] data_raddr;
    logic [DATA_W-1:0]       data_rdata;
    kind_t                   result_kind;
    logic [ADDR_W-1:0]       mem_address;
    logic [DATA_W-1:0]       data_out;
    logic                    was_hit;

    dmc_ctrl #(
        .NUM_LINES      (NUM_LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .WORD_BYTES     (WORD_BYTES),
        .IDX_W          (IDX_W),
        .WSEL_W         (WSEL_W),
        .OFF_W          (OFF_W),
        .TAG_W          (TAG_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .req_type    (s_tuser[1:0]),
        .address     (s_tdata[ADDR_W-1:0]),
        .data_in     (s_tdata[ADDR_W +: DATA_W]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .result_kind (result_kind),
        .mem_address (mem_address),
        .data_out    (data_out),
        .was_hit     (was_hit),
        .last        (m_tlast),
        .meta_we     (meta_we),
        .meta_waddr  (meta_waddr),
        .meta_wdata  (meta_wdata),
        .meta_re     (meta_re),
        .meta_raddr  (meta_raddr),
        .meta_rdata  (meta_rdata),
        .data_we     (data_we),
        .data_waddr  (data_waddr),
        .data_wdata  (data_wdata),
        .data_re     (data_re),
        .data_raddr  (data_raddr),
        .data_rdata  (data_rdata)
    );

    dmc_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_LINES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_LINES * WORDS_PER_LINE)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    assign m_tdata = {data_out, mem_address};
    assign m_tuser = {was_hit, result_kind};

endmodule

@@ hdl/dmc_checker.sv @@
// Port-level checks of the cache, bound to the top level.
module dmc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [dmc_pkg::TDATA_W-1:0]   m_tdata,
    input  logic [dmc_pkg::M_USER_W-1:0]  m_tuser,
    input  logic                          m_tlast
);

    import dmc_pkg::*;

    // a stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result dropped or changed while stalled");

    // access results always close the item
    a_access_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_READ || m_tuser[1:0] == KIND_WRITE) |-> m_tlast)
        else $error("access result without last");

    // a writeback word is always followed by more results
    a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_WB |-> !m_tlast)
        else $error("writeback word marked last");

    a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == KIND_READ || m_tuser[1:0] == KIND_WRITE))
        else $error("hit flag on a memory-side result");

    // no new word is taken while a miss is still streaming its victim
    a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_WB |-> !s_tready)
        else $error("input taken during writeback");

endmodule

bind direct_mapped_writeback_cache dmc_checker u_dmc_checker (.*);
